// ===== hw/rtl/vas_pkg.sv =====
package vas_pkg;

    localparam int POS_W   = 24;
    localparam int PRS_W   = 17;
    localparam int RAW_W   = 16;
    localparam int TIME_W  = 48;
    localparam int SPD_W   = 24;
    localparam int WGT_W   = 17;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;

    localparam logic [TIME_W-1:0] STALE_US  = 48'd100000;
    localparam logic [WGT_W-1:0]  Q16_ONE   = 17'd65536;
    localparam logic [SPD_W-1:0]  SPEED_MAX = 24'hFFFFFF;

    localparam logic [IDX_W-1:0] REG_HSL = 3'd0;
    localparam logic [IDX_W-1:0] REG_HSH = 3'd1;
    localparam logic [IDX_W-1:0] REG_HWL = 3'd2;
    localparam logic [IDX_W-1:0] REG_HWH = 3'd3;
    localparam logic [IDX_W-1:0] REG_DSL = 3'd4;
    localparam logic [IDX_W-1:0] REG_DSH = 3'd5;
    localparam logic [IDX_W-1:0] REG_DWL = 3'd6;
    localparam logic [IDX_W-1:0] REG_DWH = 3'd7;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_SQRT,
        ST_SPDMUL,
        ST_SPDDIV,
        ST_SPDSAT,
        ST_WSEL,
        ST_WMUL,
        ST_WDIV,
        ST_STEP,
        ST_OUT
    } vas_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sample;
        logic sqrt_init;
        logic sqrt_step;
        logic spd_mul;
        logic div_init;
        logic div_step;
        logic spd_sat;
        logic wsel;
        logic wmul;
        logic wdiv_done;
        logic step;
        logic out_load;
    } vas_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic fresh;
        logic speed_upd;
        logic need_interp;
        logic sqrt_done;
        logic div_done;
    } vas_sts_t;

endpackage

// ===== hw/rtl/vas_ctrl.sv =====
module vas_ctrl
    import vas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  vas_sts_t   sts,
    output vas_cmd_t   cmd
);

    vas_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SAMPLE;
            ST_SAMPLE:
            begin
                if (sts.is_tick)
                    state_next = sts.fresh ? ST_WSEL : ST_OUT;
                else
                    state_next = sts.speed_upd ? ST_SQRT : ST_OUT;
            end
            ST_SQRT:   if (sts.sqrt_done) state_next = ST_SPDMUL;
            ST_SPDMUL: state_next = ST_SPDDIV;
            ST_SPDDIV: if (sts.div_done) state_next = ST_SPDSAT;
            ST_SPDSAT: state_next = ST_OUT;
            ST_WSEL:   state_next = sts.need_interp ? ST_WMUL : ST_STEP;
            ST_WMUL:   state_next = ST_WDIV;
            ST_WDIV:   if (sts.div_done) state_next = ST_STEP;
            ST_STEP:   state_next = ST_OUT;
            ST_OUT:    if (!ovalid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        ovalid_next = ovalid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:   cmd.load = in_valid;
            ST_SAMPLE:
            begin
                cmd.sample    = 1'b1;
                cmd.sqrt_init = 1'b1;
            end
            ST_SQRT:   cmd.sqrt_step = 1'b1;
            ST_SPDMUL:
            begin
                cmd.spd_mul  = 1'b1;
                cmd.div_init = 1'b1;
            end
            ST_SPDDIV: cmd.div_step = 1'b1;
            ST_SPDSAT: cmd.spd_sat = 1'b1;
            ST_WSEL:   cmd.wsel = 1'b1;
            ST_WMUL:
            begin
                cmd.wmul     = 1'b1;
                cmd.div_init = 1'b1;
            end
            ST_WDIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.wdiv_done = sts.div_done;
            end
            ST_STEP:   cmd.step = 1'b1;
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SAMPLE));
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid);
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid);

endmodule

// ===== hw/rtl/vas_dp.sv =====
module vas_dp
    import vas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  vas_cmd_t                 cmd,
    output vas_sts_t                 sts,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     opcode,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic [PRS_W-1:0]         pen_pressure,
    input  logic [RAW_W-1:0]         raw_pressure,
    input  logic [TIME_W-1:0]        time_us,
    output logic signed [POS_W-1:0]  out_x,
    output logic signed [POS_W-1:0]  out_y,
    output logic [PRS_W-1:0]         out_pressure,
    output logic                     stepped
);

    // configuration
    logic [SPD_W-1:0] hsl_reg, hsh_reg, dsl_reg, dsh_reg;
    logic [WGT_W-1:0] hwl_reg, hwh_reg, dwl_reg, dwh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsl_reg <= 24'd0;
            hsh_reg <= 24'd25600;
            hwl_reg <= 17'd41288;
            hwh_reg <= 17'd41288;
            dsl_reg <= 24'd51200;
            dsh_reg <= 24'd76800;
            dwl_reg <= 17'd41288;
            dwh_reg <= 17'd41288;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HSL: hsl_reg <= cfg_data;
                REG_HSH: hsh_reg <= cfg_data;
                REG_HWL: hwl_reg <= cfg_data[WGT_W-1:0];
                REG_HWH: hwh_reg <= cfg_data[WGT_W-1:0];
                REG_DSL: dsl_reg <= cfg_data;
                REG_DSH: dsh_reg <= cfg_data;
                REG_DWL: dwl_reg <= cfg_data[WGT_W-1:0];
                REG_DWH: dwh_reg <= cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic                    op_reg;
    logic signed [POS_W-1:0] px_reg, py_reg;
    logic [PRS_W-1:0]        pr_reg;
    logic                    drg_in_reg;
    logic [TIME_W-1:0]       t_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= opcode;
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            pr_reg     <= (pen_pressure > Q16_ONE) ? Q16_ONE : pen_pressure;
            drg_in_reg <= (raw_pressure != '0);
            t_reg      <= time_us;
        end
    end

    // filter state
    logic signed [POS_W-1:0] sx_reg, sy_reg, gx_reg, gy_reg, lx_reg, ly_reg;
    logic [PRS_W-1:0]        sp_reg, gp_reg;
    logic                    gdrag_reg;
    logic [TIME_W-1:0]       prev_t_reg;
    logic [SPD_W-1:0]        speed_reg;
    logic                    stepped_reg;

    logic              t_after;
    logic [TIME_W-1:0] dt;
    logic              fresh;
    assign t_after = t_reg > prev_t_reg;
    assign dt      = t_reg - prev_t_reg;
    assign fresh   = !(t_after && (dt > STALE_US));

    // distance squared: dx, dy fit in 25 bits, sum in 50 bits
    logic signed [POS_W:0] dx, dy;
    assign dx = {px_reg[POS_W-1], px_reg} - {lx_reg[POS_W-1], lx_reg};
    assign dy = {py_reg[POS_W-1], py_reg} - {ly_reg[POS_W-1], ly_reg};

    // shared working registers
    localparam int SQ_W  = 50;
    localparam int RT_W  = 25;
    localparam int NUM_W = 46;  // dist * 1e6 and weight numerator
    localparam int DEN_W = 48;

    logic [SQ_W-1:0]  sq_rem_reg, sq_res_reg, sq_bit_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   drem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [5:0]       dcnt_reg;
    logic [WGT_W-1:0] w_reg, wl_reg, wh_reg;
    logic [SPD_W-1:0] p_reg, d_reg;
    logic [SQ_W-1:0]  dx2_reg, dy2_reg;

    logic [SQ_W-1:0] sq_try;
    assign sq_try = sq_res_reg + sq_bit_reg;

    logic [DEN_W:0] drem_sh;
    assign drem_sh = {drem_reg[DEN_W-1:0], num_reg[NUM_W-1]};

    // weight selection
    logic [SPD_W-1:0] sl, sh;
    logic [WGT_W-1:0] wl_s, wh_s;
    always_comb
    begin
        sl   = gdrag_reg ? dsl_reg : hsl_reg;
        sh   = gdrag_reg ? dsh_reg : hsh_reg;
        wl_s = gdrag_reg ? dwl_reg : hwl_reg;
        wh_s = gdrag_reg ? dwh_reg : hwh_reg;
        if (wl_s > Q16_ONE) wl_s = Q16_ONE;
        if (wh_s > Q16_ONE) wh_s = Q16_ONE;
    end

    logic interp;
    assign interp = (speed_reg >= sl) && (speed_reg <= sh) && (sh > sl);

    // step: diff * w, 25 x 17 bits
    function automatic logic signed [POS_W-1:0] approach(
        input logic signed [POS_W-1:0] cur,
        input logic signed [POS_W-1:0] goal,
        input logic [WGT_W-1:0]        w
    );
        logic signed [POS_W:0]   diff;
        logic signed [POS_W+18:0] prod;
        logic signed [POS_W+18:0] q;
        logic signed [POS_W+1:0] sum;
        diff = {goal[POS_W-1], goal} - {cur[POS_W-1], cur};
        prod = diff * $signed({1'b0, w}) + 43'sd32768;
        q    = prod >>> 16;
        sum  = {{1{cur[POS_W-1]}}, cur[POS_W-1], cur} + q[POS_W+1:0];
        return sum[POS_W-1:0];
    endfunction

    logic signed [POS_W-1:0] sp_ext, gp_ext, sp_new;
    assign sp_ext = {{(POS_W-PRS_W){1'b0}}, sp_reg};
    assign gp_ext = {{(POS_W-PRS_W){1'b0}}, gp_reg};
    assign sp_new = approach(sp_ext, gp_ext, w_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg     <= '0;
            sy_reg     <= '0;
            sp_reg     <= '0;
            gx_reg     <= '0;
            gy_reg     <= '0;
            gp_reg     <= '0;
            gdrag_reg  <= 1'b0;
            prev_t_reg <= '0;
            speed_reg  <= '0;
            lx_reg     <= '0;
            ly_reg     <= '0;
        end
        else
        begin
            if (cmd.sample && op_reg == OP_SAMPLE)
            begin
                gx_reg    <= px_reg;
                gy_reg    <= py_reg;
                gp_reg    <= pr_reg;
                gdrag_reg <= drg_in_reg;
                if (!fresh)
                begin
                    sx_reg <= px_reg;
                    sy_reg <= py_reg;
                    sp_reg <= pr_reg;
                end
                if (t_reg != prev_t_reg)
                begin
                    if (!t_after) speed_reg <= '0;
                    lx_reg <= px_reg;
                    ly_reg <= py_reg;
                end
            end
            if (cmd.spd_sat)
            begin
                speed_reg  <= (quo_reg > NUM_W'(SPEED_MAX)) ? SPEED_MAX
                                                             : quo_reg[SPD_W-1:0];
            end
            if (cmd.out_load && op_reg == OP_SAMPLE)
                prev_t_reg <= t_reg;
            if (cmd.step)
            begin
                sx_reg <= approach(sx_reg, gx_reg, w_reg);
                sy_reg <= approach(sy_reg, gy_reg, w_reg);
                sp_reg <= sp_new[PRS_W-1:0];
            end
        end
    end

    // arithmetic sequencing
    always_ff @(posedge clk)
    begin
        if (cmd.sample)
            den_reg <= dt;
        if (cmd.spd_mul)
            num_reg <= NUM_W'(sq_res_reg[RT_W-1:0] * 20'd1000000);
        if (cmd.wsel)
        begin
            w_reg  <= (speed_reg >= sh) ? wh_s : wl_s;
            wl_reg <= wl_s;
            wh_reg <= wh_s;
            p_reg  <= speed_reg - sl;
            d_reg  <= sh - sl;
            den_reg <= {{(DEN_W-SPD_W){1'b0}}, sh - sl};
        end
        if (cmd.wmul)
            num_reg <= NUM_W'(wl_reg * (d_reg - p_reg)) + NUM_W'(wh_reg * p_reg);
        if (cmd.div_init)
        begin
            drem_reg <= '0;
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step && dcnt_reg != 6'(NUM_W))
        begin
            num_reg  <= num_reg << 1;
            dcnt_reg <= dcnt_reg + 6'd1;
            if (drem_sh >= {1'b0, den_reg})
            begin
                drem_reg <= drem_sh - {1'b0, den_reg};
                quo_reg  <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= drem_sh;
                quo_reg  <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.wdiv_done)
            w_reg <= quo_reg[WGT_W-1:0];
    end

    // sqrt: one result bit per cycle, first cycle loads the radicand
    logic sq_first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_first_reg <= 1'b0;
        else if (cmd.sqrt_init)
            sq_first_reg <= 1'b1;
        else if (cmd.sqrt_step)
            sq_first_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            dx2_reg    <= SQ_W'(dx * dx);
            dy2_reg    <= SQ_W'(dy * dy);
            sq_res_reg <= '0;
            sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_first_reg)
                sq_rem_reg <= dx2_reg + dy2_reg;
            else if (sq_bit_reg != '0)
            begin
                if (sq_rem_reg >= sq_try)
                begin
                    sq_rem_reg <= sq_rem_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_x        <= (cmd.step) ? sx_reg : sx_reg;
            out_y        <= sy_reg;
            out_pressure <= sp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stepped_reg <= 1'b0;
        else if (cmd.out_load)
            stepped_reg <= (op_reg == OP_TICK) && fresh;
    end
    assign stepped = stepped_reg;

    always_comb
    begin
        sts.is_tick     = (op_reg == OP_TICK);
        sts.fresh       = fresh;
        sts.speed_upd   = t_after;
        sts.need_interp = interp;
        sts.sqrt_done   = !sq_first_reg && (sq_bit_reg == '0);
        sts.div_done    = (dcnt_reg == 6'(NUM_W));
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (w_reg <= Q16_ONE));
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.spd_sat |-> (dcnt_reg == 6'(NUM_W)));
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_pressure <= Q16_ONE));

endmodule

// ===== hw/rtl/velocity_adaptive_smoothing.sv =====
// Velocity adaptive smoothing of pen position and pressure. Each input
// transaction (sample, opcode 0, or tick, opcode 1) yields exactly one output
// transaction holding the smoothed position and pressure after it. One item is
// processed at a time; a tick that moves the output steps directly with the
// weight at a breakpoint, or first interpolates the weight through a 46-step
// restoring divider; a sample that updates speed runs a square root
// (radicand load, 25 steps, done) and then the same divider; other items go
// straight to the output. Output is registered; a stalled output holds back
// the next item, since the next item is taken only once the result has been
// handed to the output register. Configuration writes are taken at any time
// but belong to idle periods.
module velocity_adaptive_smoothing
    import vas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic [PRS_W-1:0]         pen_pressure,
    input  logic [RAW_W-1:0]         raw_pressure,
    input  logic [TIME_W-1:0]        time_us,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [POS_W-1:0]  out_x,
    output logic signed [POS_W-1:0]  out_y,
    output logic [PRS_W-1:0]         out_pressure,
    output logic                     stepped
);

    vas_cmd_t cmd;
    vas_sts_t sts;

    vas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vas_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (opcode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pen_pressure (pen_pressure),
        .raw_pressure (raw_pressure),
        .time_us      (time_us),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_pressure (out_pressure),
        .stepped      (stepped)
    );

endmodule
